### rtl/b58_pkg.sv
// Shared constants, state type and character lookup for the Base58 encoder.
`default_nettype none

package b58_pkg;

  localparam int MAX_INPUT_BYTES = 32;
  localparam int DIGIT_DEPTH     = 64;
  localparam int MAX_RESULTS     = 44;

  localparam int B58_BASE    = 58;
  localparam int RECIP_58    = 1129;   // floor(2^16 / 58)
  localparam int RECIP_SHIFT = 16;

  localparam int DIGIT_W = 6;
  localparam int BYTE_W  = 8;
  localparam int CHAR_W  = 7;

  localparam int DIGIT_AW = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
  localparam int DCNT_W   = $clog2(DIGIT_DEPTH + 1);
  localparam int BCNT_W   = $clog2(MAX_INPUT_BYTES + 1);
  localparam int RES_W    = $clog2(MAX_RESULTS + 1);
  localparam int TOT_W    = $clog2(MAX_INPUT_BYTES + DIGIT_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_ONE = 7'd49;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_APPEND,
    ST_EMIT_INIT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } b58_state_t;

  // Alphabet 123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz
  function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CHAR_ONE;
    if (d < 6'd9) begin
      c = 7'(7'd49 + 7'(d));
    end else if (d < 6'd17) begin
      c = 7'(7'd65 + 7'(d - 6'd9));
    end else if (d < 6'd22) begin
      c = 7'(7'd74 + 7'(d - 6'd17));
    end else if (d < 6'd33) begin
      c = 7'(7'd80 + 7'(d - 6'd22));
    end else if (d < 6'd44) begin
      c = 7'(7'd97 + 7'(d - 6'd33));
    end else if (d < 6'd58) begin
      c = 7'(7'd109 + 7'(d - 6'd44));
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/b58_if.sv
// Handshake channel interfaces for the byte input and the character output.
`default_nettype none

interface b58_in_if import b58_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b58_out_if import b58_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              out_error;

  modport source (output valid, output out_char, output out_last, output out_error,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input out_error,
                  output ready);
endinterface

`default_nettype wire

### rtl/b58_div58.sv
// One digit step: {digit, carry} split into quotient and remainder by 58.
`default_nettype none

module b58_div58 import b58_pkg::*; (
  input  logic [DIGIT_W-1:0] hi_digit,
  input  logic [BYTE_W-1:0]  lo_carry,
  output logic [BYTE_W-1:0]  quot,
  output logic [DIGIT_W-1:0] rem_digit
);

  localparam int V_W = DIGIT_W + BYTE_W;
  localparam int P_W = V_W + 11;

  logic [V_W-1:0]   v;
  logic [P_W-1:0]   prod;
  logic [8:0]       q_est;
  logic [V_W:0]     qm;
  logic [6:0]       r_est;

  assign v     = {hi_digit, lo_carry};
  assign prod  = P_W'(v) * P_W'(RECIP_58);
  // reciprocal underestimates by at most one
  assign q_est = prod[RECIP_SHIFT +: 9];
  assign qm    = (V_W + 1)'(q_est) * (V_W + 1)'(B58_BASE);
  assign r_est = 7'((V_W + 1)'(v) - qm);

  always_comb begin
    if (r_est >= 7'(B58_BASE)) begin
      rem_digit = 6'(r_est - 7'(B58_BASE));
      quot      = 8'(q_est + 9'd1);
    end else begin
      rem_digit = 6'(r_est);
      quot      = 8'(q_est);
    end
  end

endmodule

`default_nettype wire

### rtl/base58_encoder.sv
// Base58 encoder top level: digit store, fold sequencer and character emitter.
//
//   channel   dir  payload                          transfer when
//   in_ch     in   in_byte[7:0], in_last            in_ch.valid & in_ch.ready
//   out_ch    out  out_char[6:0], out_last, out_error  out_ch.valid & out_ch.ready
//
// A byte is accepted, then each stored digit passes through the carry sweep
// (the digit memory has one read port and one write port), then new top
// digits are appended while carry remains. The last byte adds a setup step
// and, per character, a memory read, then a load of the output register that
// waits while out_ch stalls.
// Reset (synchronous, rst_n low) clears the state, counters and flags only;
// the digit memory is tracked by its fill count and never cleared.
// in_ch is ready only in the idle state, i.e. when no sweep, append or emission runs.
`default_nettype none

module base58_encoder import b58_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  b58_in_if.sink       in_ch,
  b58_out_if.source    out_ch
);

  // control state
  b58_state_t          state_r, state_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;     // digits in use
  logic [BCNT_W-1:0]   zcnt_r, zcnt_nxt;     // leading zero bytes
  logic [BCNT_W-1:0]   bcnt_r, bcnt_nxt;     // bytes folded
  logic                seen_r, seen_nxt;
  logic                ovf_r, ovf_nxt;
  logic                last_r, last_nxt;
  logic                ovalid_r, ovalid_nxt;

  // datapath
  logic [BYTE_W-1:0]   carry_r, carry_nxt;
  logic [DIGIT_AW-1:0] j_r, j_nxt;
  logic [DIGIT_AW-1:0] idx_r, idx_nxt;
  logic [RES_W-1:0]    kcnt_r, kcnt_nxt;
  logic [RES_W-1:0]    nres_r, nres_nxt;
  logic                err_r, err_nxt;
  logic [CHAR_W-1:0]   ochar_r, ochar_nxt;
  logic                olast_r, olast_nxt;
  logic                oerr_r, oerr_nxt;

  // digit memory, least significant digit at address 0
  logic [DIGIT_W-1:0]  mem [DIGIT_DEPTH];
  logic [DIGIT_W-1:0]  rdata_r;
  logic [DIGIT_AW-1:0] raddr, waddr;
  logic [DIGIT_W-1:0]  wdata;
  logic                we;

  // divide-by-58 step
  logic [DIGIT_W-1:0]  div_hi;
  logic [BYTE_W-1:0]   div_q;
  logic [DIGIT_W-1:0]  div_r;

  logic                in_xfer;
  logic [TOT_W-1:0]    total;
  logic                prefix_char;
  logic                final_char;

  b58_div58 u_div (
    .hi_digit  (div_hi),
    .lo_carry  (carry_r),
    .quot      (div_q),
    .rem_digit (div_r)
  );

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign in_xfer          = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = ovalid_r;
  assign out_ch.out_char  = ochar_r;
  assign out_ch.out_last  = olast_r;
  assign out_ch.out_error = oerr_r;

  assign div_hi      = (state_r == ST_SWEEP) ? rdata_r : '0;
  assign total       = TOT_W'(zcnt_r) + TOT_W'(dcnt_r);
  assign prefix_char = TOT_W'(kcnt_r) < TOT_W'(zcnt_r);
  assign final_char  = (RES_W'(kcnt_r + 1'b1) == nres_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      dcnt_r   <= '0;
      zcnt_r   <= '0;
      bcnt_r   <= '0;
      seen_r   <= 1'b0;
      ovf_r    <= 1'b0;
      last_r   <= 1'b0;
      ovalid_r <= 1'b0;
      kcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      dcnt_r   <= dcnt_nxt;
      zcnt_r   <= zcnt_nxt;
      bcnt_r   <= bcnt_nxt;
      seen_r   <= seen_nxt;
      ovf_r    <= ovf_nxt;
      last_r   <= last_nxt;
      ovalid_r <= ovalid_nxt;
      kcnt_r   <= kcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    j_r     <= j_nxt;
    idx_r   <= idx_nxt;
    nres_r  <= nres_nxt;
    err_r   <= err_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    dcnt_nxt   = dcnt_r;
    zcnt_nxt   = zcnt_r;
    bcnt_nxt   = bcnt_r;
    seen_nxt   = seen_r;
    ovf_nxt    = ovf_r;
    last_nxt   = last_r;
    carry_nxt  = carry_r;
    j_nxt      = j_r;
    idx_nxt    = idx_r;
    kcnt_nxt   = kcnt_r;
    nres_nxt   = nres_r;
    err_nxt    = err_r;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    oerr_nxt   = oerr_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    raddr      = '0;
    waddr      = j_r;
    wdata      = div_r;
    we         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          last_nxt = in_ch.in_last;
          if (bcnt_r < BCNT_W'(MAX_INPUT_BYTES)) begin
            bcnt_nxt  = BCNT_W'(bcnt_r + 1'b1);
            if (in_ch.in_byte == '0 && !seen_r) begin
              zcnt_nxt = BCNT_W'(zcnt_r + 1'b1);
            end
            if (in_ch.in_byte != '0) begin
              seen_nxt = 1'b1;
            end
            carry_nxt = in_ch.in_byte;
            j_nxt     = '0;
            // read of digit 0 issued now, data ready in the sweep's first cycle
            state_nxt = (dcnt_r == '0) ? ST_APPEND : ST_SWEEP;
          end else begin
            // byte past capacity: dropped, but a last flag still ends the string
            ovf_nxt = 1'b1;
            if (in_ch.in_last) begin
              state_nxt = ST_EMIT_INIT;
            end
          end
        end
      end

      ST_SWEEP: begin
        // digit j arrives from memory; digit j+1 is read meanwhile
        we        = 1'b1;
        waddr     = j_r;
        carry_nxt = div_q;
        raddr     = DIGIT_AW'(j_r + 1'b1);
        j_nxt     = DIGIT_AW'(j_r + 1'b1);
        if (DCNT_W'(DCNT_W'(j_r) + 1'b1) == dcnt_r) begin
          state_nxt = ST_APPEND;
        end
      end

      ST_APPEND: begin
        if (carry_r == '0) begin
          state_nxt = last_r ? ST_EMIT_INIT : ST_IDLE;
        end else if (dcnt_r == DCNT_W'(DIGIT_DEPTH)) begin
          // store full: remaining carry is lost
          ovf_nxt   = 1'b1;
          state_nxt = last_r ? ST_EMIT_INIT : ST_IDLE;
        end else begin
          we        = 1'b1;
          waddr     = dcnt_r[DIGIT_AW-1:0];
          dcnt_nxt  = DCNT_W'(dcnt_r + 1'b1);
          carry_nxt = div_q;
        end
      end

      ST_EMIT_INIT: begin
        kcnt_nxt = '0;
        idx_nxt  = DIGIT_AW'(dcnt_r - 1'b1);
        if (total > TOT_W'(MAX_RESULTS)) begin
          nres_nxt = RES_W'(MAX_RESULTS);
          err_nxt  = 1'b1;
        end else begin
          nres_nxt = RES_W'(total);
          err_nxt  = ovf_r;
        end
        state_nxt = ST_EMIT_RD;
      end

      ST_EMIT_RD: begin
        raddr     = idx_r;
        state_nxt = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        raddr = idx_r;
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = final_char;
          oerr_nxt   = err_r;
          kcnt_nxt   = RES_W'(kcnt_r + 1'b1);
          if (prefix_char) begin
            ochar_nxt = CHAR_ONE;
          end else begin
            ochar_nxt = b58_char(rdata_r);
            idx_nxt   = DIGIT_AW'(idx_r - 1'b1);
          end
          if (final_char) begin
            // string done: back to the empty value
            dcnt_nxt  = '0;
            zcnt_nxt  = '0;
            bcnt_nxt  = '0;
            seen_nxt  = 1'b0;
            ovf_nxt   = 1'b0;
            last_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_dcnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= DCNT_W'(DIGIT_DEPTH))
    else $error("digit count beyond store depth");

  a_sweep_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> DCNT_W'(j_r) < dcnt_r)
    else $error("sweep index past last stored digit");

  a_zero_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    zcnt_r <= bcnt_r)
    else $error("more leading zeros than bytes folded");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_RD || state_r == ST_EMIT_LD) |-> kcnt_r < nres_r)
    else $error("character index past run length");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LD && (!ovalid_r || out_ch.ready) && final_char)
      |=> (ovalid_r && olast_r && state_r == ST_IDLE && dcnt_r == '0))
    else $error("final character did not close the run");
`endif

endmodule

`default_nettype wire

### bench/base58_encoder_tb.sv
// Self-checking bench for base58_encoder: byte strings in, characters checked.
`default_nettype none

module base58_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b58_pkg::*;

  // No-transfer cycles tolerated before the run is declared hung. Worst honest
  // case is a full-store fold plus the longest sender gap and the longest
  // receiver stall, so this leaves ample margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 100;
  localparam int TARGET_BYTES   = 500;

  // Alphabet packed MSB first: digit d sits at bits [8*(57-d) +: 8].
  localparam logic [8*58-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              drain;   // hold off until every queued character is out
  } feed_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              err;
  } enc_char_t;

  typedef logic [BYTE_W-1:0] byte_str_t [$];

  logic clk;
  logic rst_n;

  b58_in_if  in_ch ();
  b58_out_if out_ch ();

  base58_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bytes still to be offered, and characters still owed by the block.
  feed_item_t byte_feed [$];
  enc_char_t  pending_chars [$];

  // Encoder model state: base-58 digits, least significant first.
  logic [DIGIT_W-1:0] digits [DIGIT_DEPTH];
  int unsigned        n_digits;
  int unsigned        zero_lead;
  int unsigned        bytes_taken;
  bit                 nonzero_seen;
  bit                 truncated;

  // Bookkeeping
  int unsigned bytes_total;
  int unsigned bytes_accepted;
  int unsigned chars_checked;
  int unsigned strings_done;
  int unsigned strings_cut;
  int unsigned longest_run;
  int unsigned mismatches;
  int unsigned idle_cycles;
  logic [31:0] cyc;
  int          in_gap;
  int          out_stall;

  // Calm windows: stretches where one side starts no new gap or stall.
  wire in_calm  = (cyc[9:7] == 3'd0);
  wire out_calm = (cyc[9:7] == 3'd4);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic log_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function void clear_encoder();
    for (int i = 0; i < DIGIT_DEPTH; i++) digits[i] = '0;
    n_digits     = 0;
    zero_lead    = 0;
    bytes_taken  = 0;
    nonzero_seen = 1'b0;
    truncated    = 1'b0;
  endfunction

  // Folds one accepted byte into the digit array; on the last byte, queues the
  // characters of the whole string and returns to the cleared state.
  function void fold_in_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned carry;
    int unsigned total;
    int unsigned n_out;
    int unsigned pos;
    int unsigned j;
    int unsigned k;
    enc_char_t   c;
    if (bytes_taken < MAX_INPUT_BYTES) begin
      bytes_taken++;
      if (b == '0 && !nonzero_seen) zero_lead++;
      if (b != '0) nonzero_seen = 1'b1;
      carry = b;
      for (j = 0; j < n_digits; j++) begin
        carry     = carry + 256 * digits[j];
        digits[j] = DIGIT_W'(carry % 58);
        carry     = carry / 58;
      end
      // grow the top while carry remains; anything past the store is lost
      while (carry != 0 && n_digits < DIGIT_DEPTH) begin
        digits[n_digits] = DIGIT_W'(carry % 58);
        n_digits++;
        carry = carry / 58;
      end
      if (carry != 0) truncated = 1'b1;
    end else begin
      // beyond capacity: byte dropped, string flagged
      truncated = 1'b1;
    end
    if (!last) return;

    total = zero_lead + n_digits;
    n_out = total;
    if (total > MAX_RESULTS) begin
      n_out     = MAX_RESULTS;
      truncated = 1'b1;
    end
    for (k = 0; k < n_out; k++) begin
      if (k < zero_lead) begin
        c.ch = CHAR_ONE;
      end else begin
        pos  = n_digits - 1 - (k - zero_lead);
        c.ch = ALPHABET[8 * (57 - digits[pos]) +: CHAR_W];
      end
      c.last = (k + 1 == n_out);
      c.err  = truncated;
      pending_chars.push_back(c);
    end
    strings_done++;
    if (truncated) strings_cut++;
    if (n_out > longest_run) longest_run = n_out;
    clear_encoder();
  endfunction

  task automatic queue_string(input byte_str_t s, input bit drain);
    feed_item_t itm;
    for (int i = 0; i < s.size(); i++) begin
      itm.data  = s[i];
      itm.last  = (i == s.size() - 1);
      itm.drain = drain && (i == 0);
      byte_feed.push_back(itm);
    end
  endtask

  // Stimulus: directed strings, three corner strings, then random strings.
  initial begin : stimulus
    byte_str_t s;
    int        cls;
    int        len;
    int        lead;
    int        made;

    rst_n = 1'b0;

    // Directed: single zero, byte extremes, all-zero string, digit roll-over
    // at 58, leading zeros ahead of data, zero tail bytes.
    s = '{8'h00};                      queue_string(s, 1'b0);
    s = '{8'hff};                      queue_string(s, 1'b0);
    s = '{8'h01};                      queue_string(s, 1'b0);
    s = '{8'h00, 8'h00, 8'h00};        queue_string(s, 1'b0);
    s = '{8'h39};                      queue_string(s, 1'b0);
    s = '{8'h3a};                      queue_string(s, 1'b0);
    s = '{8'h00, 8'h01};               queue_string(s, 1'b0);
    s = '{8'h00, 8'h00, 8'hff, 8'h80}; queue_string(s, 1'b0);
    s = '{8'h01, 8'h00};               queue_string(s, 1'b0);
    s = '{8'h80, 8'h00, 8'hff};        queue_string(s, 1'b0);

    // Corners: full-length maximum value (longest run), over-length string
    // whose last flag lands on a dropped byte, full-length all-zero string.
    s = {};
    repeat (MAX_INPUT_BYTES) s.push_back(8'hff);
    queue_string(s, 1'b1);
    s = {};
    repeat (MAX_INPUT_BYTES + 4) s.push_back(pick_byte());
    queue_string(s, 1'b0);
    s = {};
    repeat (MAX_INPUT_BYTES) s.push_back(8'h00);
    queue_string(s, 1'b0);

    made = 0;
    while (byte_feed.size() < TARGET_BYTES) begin
      s    = {};
      cls  = $urandom_range(0, 99);
      lead = 0;
      if (cls < 50) begin
        len = $urandom_range(1, 6);
      end else if (cls < 65) begin
        lead = $urandom_range(1, 4);
        len  = $urandom_range(1, 6);
      end else if (cls < 73) begin
        lead = $urandom_range(1, 8);
        len  = 0;
      end else if (cls < 86) begin
        len = $urandom_range(7, 20);
      end else if (cls < 94) begin
        len = MAX_INPUT_BYTES;
      end else begin
        len = $urandom_range(MAX_INPUT_BYTES + 1, MAX_INPUT_BYTES + 8);
      end
      repeat (lead) s.push_back(8'h00);
      repeat (len) s.push_back(pick_byte());
      queue_string(s, (made % 16) == 7);
      made++;
    end
    bytes_total = byte_feed.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // All bytes taken, then every owed character seen, then a quiet tail.
    while (bytes_accepted != bytes_total) @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d strings from %0d bytes, %0d over capacity; %0d characters checked",
             strings_done, bytes_total, strings_cut, chars_checked);
    $display("longest run %0d characters, %0d mismatches", longest_run, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Byte driver. A string flagged for drain waits until the block has
  // delivered everything owed and no transfer is landing this edge.
  always @(posedge clk) begin : drive
    feed_item_t itm;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= '0;
      in_ch.in_last <= 1'b0;
      in_gap        <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap != 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (byte_feed.size() != 0 &&
                   !(byte_feed[0].drain && (pending_chars.size() != 0 || in_ch.valid))) begin
        itm = byte_feed.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= itm.data;
        in_ch.in_last <= itm.last;
        in_gap        <= in_calm ? 0 : pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each byte transfer, checks each character transfer
  // against the oldest owed one, and throttles out_ch.ready.
  always @(posedge clk) begin : observe
    enc_char_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
      clear_encoder();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fold_in_byte(in_ch.in_byte, in_ch.in_last);
        bytes_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_chars.size() == 0) begin
          log_mismatch($sformatf("unexpected char 0x%02h", out_ch.out_char));
        end else begin
          want = pending_chars.pop_front();
          chars_checked++;
          if (out_ch.out_char !== want.ch)
            log_mismatch($sformatf("char 0x%02h, want 0x%02h", out_ch.out_char, want.ch));
          if (out_ch.out_last !== want.last)
            log_mismatch($sformatf("out_last %b, want %b", out_ch.out_last, want.last));
          if (out_ch.out_error !== want.err)
            log_mismatch($sformatf("out_error %b, want %b", out_ch.out_error, want.err));
        end
      end
      if (out_stall != 0) begin
        out_ch.ready <= 1'b0;
        out_stall    <= out_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 2) == 0) out_stall <= pick_gap();
      end
    end
  end

  // Watchdog: any transfer on either channel resets the idle count.
  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      cyc         <= '0;
      idle_cycles <= 0;
    end else begin
      cyc <= cyc + 1;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("hung: no transfer for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire

### base58_encoder.f
rtl/b58_pkg.sv
rtl/b58_if.sv
rtl/b58_div58.sv
rtl/base58_encoder.sv
bench/base58_encoder_tb.sv
